// ===== sv/sra_pkg.sv =====
package sra_pkg;

	localparam int ADDR_W   = 32;
	localparam int WORD_W   = 32;
	localparam int SIZE_W   = 16;
	localparam int ALIGN_W  = 13;
	localparam int STATUS_W = 3;

	localparam logic [WORD_W-1:0] FREE_BIT = 32'h8000_0000;
	localparam logic [WORD_W-1:0] PAD_WORD = 32'hffff_ffff;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALLOC_BACKING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED         = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREE_BACKING  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NULL_IGNORED  = 3'd4;

	// Mask of the effective alignment: the largest power of two not above
	// the request, at least four, minus one.
	function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
		logic [ALIGN_W-1:0] m;
		m = ALIGN_W'(3);
		for (int j = 2; j < ALIGN_W; j++) begin
			m[j] = |(a >> (j + 1));
		end
		return m;
	endfunction

endpackage

// ===== sv/sra_ram.sv =====
module sra_ram
	import sra_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/sra_ctrl.sv =====
module sra_ctrl
	import sra_pkg::*;
#(
	parameter int RING_BYTES = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ADDR_W-1:0]   base,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [SIZE_W-1:0]   req_size,
	input  logic [ALIGN_W-1:0]  align,
	input  logic [ADDR_W-1:0]   addr,
	output logic                done,
	output logic [ADDR_W-1:0]   result_addr,
	output logic [STATUS_W-1:0] status,
	output logic                mem_we,
	output logic [$clog2(RING_BYTES)-3:0] mem_addr,
	output logic [WORD_W-1:0]   mem_wdata,
	input  logic [WORD_W-1:0]   mem_rdata
);

	localparam int RING_WORDS = RING_BYTES / 4;
	localparam int OFF_W      = $clog2(RING_BYTES);
	localparam int IW         = OFF_W - 2;
	localparam int ABS_W      = ADDR_W + 2;
	localparam int MX         = (OFF_W > ALIGN_W) ? OFF_W : ALIGN_W;
	localparam int DW         = MX + 1;
	localparam int EW         = ((DW > SIZE_W + 1) ? DW : SIZE_W + 1) + 1;
	localparam int NW         = $clog2(RING_WORDS + 1);

	localparam logic [EW-1:0]     R_E   = EW'(RING_BYTES);
	localparam logic [WORD_W-1:0] R_W   = WORD_W'(RING_BYTES);
	localparam logic [ADDR_W:0]   R_X   = (ADDR_W + 1)'(RING_BYTES);
	localparam logic [NW-1:0]     N_MAX = NW'(RING_WORDS);

	typedef enum logic [3:0] {
		IDLE, A_ADDR, A_DATA, A_END, A_FIT, A_PAD,
		F_CHECK, F_RANGE, F_WALK, F_ADV, F_HDR
	} state_t;

	state_t              state_q;
	logic [OFF_W-1:0]    alloc_q, free_q, h_q;
	logic [SIZE_W:0]     size_q;
	logic [ALIGN_W-1:0]  mask_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                wrapped_q;
	logic [ABS_W-1:0]    abs_q;
	logic [DW-1:0]       d_q;
	logic [EW-1:0]       end_q;
	logic [IW:0]         pw_q;
	logic [ADDR_W:0]     off_q;
	logic [IW-1:0]       fw_q;
	logic [NW-1:0]       n_q;
	logic                done_q;
	logic [ADDR_W-1:0]   result_addr_q;
	logic [STATUS_W-1:0] status_q;

	logic                fit_over, in_use_w, pad_more, off_out, walk_pad, adv_stop, hdr_stop;
	logic [OFF_W-1:0]    end_wrap;
	logic [IW-1:0]       off_w;
	logic [30:0]         step;
	logic [WORD_W-1:0]   adv_sum;
	logic [OFF_W-1:0]    free_next;
	logic [ADDR_W:0]     diff;

	assign busy        = (state_q != IDLE);
	assign done        = done_q;
	assign result_addr = result_addr_q;
	assign status      = status_q;

	always_comb begin
		fit_over = (end_q > R_E);
		end_wrap = (end_q == R_E) ? '0 : end_q[OFF_W-1:0];
		if (free_q == alloc_q) begin
			in_use_w = 1'b0;
		end else if (alloc_q > free_q) begin
			in_use_w = (end_wrap >= free_q) && (end_wrap < alloc_q);
		end else begin
			in_use_w = (end_wrap >= free_q) || (end_wrap < alloc_q);
		end
		pad_more  = ((DW - 2)'(pw_q) < d_q[DW-1:2]);
		diff      = {1'b0, addr_q} - {1'b0, base};
		off_out   = off_q[ADDR_W] || (off_q >= R_X);
		off_w     = off_q[OFF_W-1:2];
		walk_pad  = (mem_rdata == PAD_WORD);
		adv_stop  = (free_q == alloc_q) || (n_q == N_MAX);
		step      = {mem_rdata[30:2], 2'b00};
		adv_sum   = WORD_W'(free_q) + {1'b0, step};
		hdr_stop  = !mem_rdata[31] || (step == '0) || (adv_sum > R_W);
		free_next = (adv_sum == R_W) ? '0 : adv_sum[OFF_W-1:0];
	end

	// Memory port: each read is issued in the state just before the one that uses
	// the data; every write lands before any later read of the same word.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			A_FIT: begin
				mem_addr = h_q[OFF_W-1:2];
				if (fit_over) begin
					mem_we    = !wrapped_q;
					mem_wdata = FREE_BIT | (R_W - WORD_W'(h_q));
				end else begin
					mem_we    = !in_use_w;
					mem_wdata = WORD_W'(end_q) - WORD_W'(h_q);
				end
			end
			A_PAD: begin
				mem_we    = pad_more;
				mem_addr  = pw_q[IW-1:0];
				mem_wdata = PAD_WORD;
			end
			F_RANGE: begin
				mem_addr = off_w - IW'(1);
			end
			F_WALK: begin
				if (walk_pad) begin
					mem_addr = fw_q - IW'(2);
				end else begin
					mem_we    = 1'b1;
					mem_addr  = fw_q - IW'(1);
					mem_wdata = mem_rdata | FREE_BIT;
				end
			end
			F_ADV: begin
				mem_addr = free_q[OFF_W-1:2];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			alloc_q   <= '0;
			free_q    <= '0;
			done_q    <= 1'b0;
			wrapped_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						size_q    <= ({1'b0, req_size} + (SIZE_W + 1)'(3)) & ~(SIZE_W + 1)'(3);
						mask_q    <= align_mask(align);
						addr_q    <= addr;
						h_q       <= alloc_q;
						wrapped_q <= 1'b0;
						state_q   <= (mode == MODE_FREE) ? F_CHECK : A_ADDR;
					end
				end
				A_ADDR: begin
					abs_q   <= ABS_W'(base) + ABS_W'(h_q) + ABS_W'(4) + ABS_W'(mask_q);
					state_q <= A_DATA;
				end
				A_DATA: begin
					d_q     <= DW'((abs_q & ~ABS_W'(mask_q)) - ABS_W'(base));
					state_q <= A_END;
				end
				A_END: begin
					end_q   <= EW'(d_q) + EW'(size_q);
					state_q <= A_FIT;
				end
				A_FIT: begin
					if (fit_over) begin
						if (!wrapped_q) begin
							h_q       <= '0;
							wrapped_q <= 1'b1;
							state_q   <= A_ADDR;
						end else begin
							result_addr_q <= '0;
							status_q      <= ST_ALLOC_BACKING;
							done_q        <= 1'b1;
							state_q       <= IDLE;
						end
					end else if (in_use_w) begin
						result_addr_q <= '0;
						status_q      <= ST_ALLOC_BACKING;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end else begin
						pw_q    <= (IW + 1)'(h_q[OFF_W-1:2]) + (IW + 1)'(1);
						state_q <= A_PAD;
					end
				end
				A_PAD: begin
					if (pad_more) begin
						pw_q <= pw_q + (IW + 1)'(1);
					end else begin
						alloc_q       <= end_wrap;
						result_addr_q <= base + ADDR_W'(d_q);
						status_q      <= ST_ALLOCATED;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end
				end
				F_CHECK: begin
					if (addr_q == '0) begin
						result_addr_q <= '0;
						status_q      <= ST_NULL_IGNORED;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end else begin
						off_q   <= diff;
						state_q <= F_RANGE;
					end
				end
				F_RANGE: begin
					if (off_out) begin
						result_addr_q <= '0;
						status_q      <= ST_FREE_BACKING;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end else begin
						fw_q    <= off_w;
						n_q     <= '0;
						state_q <= (off_w == '0) ? F_ADV : F_WALK;
					end
				end
				F_WALK: begin
					if (walk_pad) begin
						fw_q <= fw_q - IW'(1);
						if (fw_q == IW'(1)) begin
							state_q <= F_ADV;
						end
					end else begin
						state_q <= F_ADV;
					end
				end
				F_ADV: begin
					if (adv_stop) begin
						result_addr_q <= '0;
						status_q      <= ST_FREED;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end else begin
						state_q <= F_HDR;
					end
				end
				F_HDR: begin
					if (hdr_stop) begin
						result_addr_q <= '0;
						status_q      <= ST_FREED;
						done_q        <= 1'b1;
						state_q       <= IDLE;
					end else begin
						free_q  <= free_next;
						n_q     <= n_q + NW'(1);
						state_q <= F_ADV;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/scratch_ring_allocator.sv =====
// Scratch ring allocator. A command beat is taken when start is high and busy
// is low; its one result appears for a single cycle with done high, and the
// receiver cannot stall it, so it must take status and result_addr in that
// cycle. Done rises in the same cycle that busy falls. An allocate that is
// granted writes its header and one pad word for each word up to the aligned
// data address; otherwise it is handed to the backing allocator. Either may
// first wrap to the ring start when the block does not fit before the ring end.
// A free of address zero is ignored, and a free outside the ring goes to the
// backing allocator. A free inside the ring walks back over pad words until it
// stops on a header word or at the ring start, then moves the free pointer
// past free slots until it stops at a header (a slot still in use or a corrupt
// one), at the allocate pointer or at the slot bound. The single word store
// port serves one read or one write a cycle. The store is not cleared after
// reset, so there is no start-up pass.
module scratch_ring_allocator
	import sra_pkg::*;
#(
	parameter int RING_BYTES = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [SIZE_W-1:0]   req_size,
	input  logic [ALIGN_W-1:0]  align,
	input  logic [ADDR_W-1:0]   addr,
	output logic                done,
	output logic [ADDR_W-1:0]   result_addr,
	output logic [STATUS_W-1:0] status
);

	// Word index width into the store, as seen by the controller.
	localparam int IW = $clog2(RING_BYTES) - 2;

	// The ring base is word aligned, so its low two bits are dropped on write.
	logic [ADDR_W-1:0] ring_base_q;

	logic              mem_we;
	logic [IW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q <= ADDR_W'(65536);
		end else if (cfg_we) begin
			ring_base_q <= cfg_wdata & ~ADDR_W'(3);
		end
	end

	// The sequencer owns both ring pointers and drives the store port; each
	// step of a pad fill, back walk or pointer advance is one store access.
	sra_ctrl #(
		.RING_BYTES(RING_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.base       (ring_base_q),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.req_size   (req_size),
		.align      (align),
		.addr       (addr),
		.done       (done),
		.result_addr(result_addr),
		.status     (status),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	// The word store: one port, read data registered.
	sra_ram #(
		.DEPTH(RING_BYTES / 4),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule
